### design/krib_pkg.sv
// Shared types and constants for the key repeat input buffer.
package krib_pkg;

  localparam int KEY_W  = 12;
  localparam int TIME_W = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_POP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_HOLD_LIMIT    = 2'd0,
    REG_REPEAT_PERIOD = 2'd1,
    REG_FRAME_STEP    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_COMPACT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] hold_limit;
    logic [TIME_W-1:0] repeat_period;
    logic [TIME_W-1:0] frame_step;
  } cfg_t;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] held;
    logic              fire;
  } slot_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic              match;
    logic [TIME_W-1:0] match_time;
    logic              match_fire;
    logic              placed;
    logic              found;
    logic [KEY_W-1:0]  found_key;
  } wave_t;

endpackage

### design/krib_regs.sv
// Configuration register file with an APB-style access port.
module krib_regs
  import krib_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] index;
  logic       wr_en;

  assign index  = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_limit    <= TIME_W'(250);
      cfg.repeat_period <= TIME_W'(50);
      cfg.frame_step    <= TIME_W'(17);
    end else if (wr_en) begin
      case (index)
        REG_HOLD_LIMIT:    cfg.hold_limit    <= pwdata[TIME_W-1:0];
        REG_REPEAT_PERIOD: cfg.repeat_period <= pwdata[TIME_W-1:0];
        REG_FRAME_STEP:    cfg.frame_step    <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_HOLD_LIMIT:    prdata = DATA_W'(cfg.hold_limit);
      REG_REPEAT_PERIOD: prdata = DATA_W'(cfg.repeat_period);
      REG_FRAME_STEP:    prdata = DATA_W'(cfg.frame_step);
      default:           prdata = '0;
    endcase
  end

endmodule

### design/krib_cell.sv
// One slot of the buffer: holds a key and its timer and passes the command wave on.
module krib_cell
  import krib_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  wave_t wave_in,
  output wave_t wave_out,
  input  logic  shift_en,
  input  logic  hole_in,
  output logic  hole_out,
  input  slot_t next_slot,
  output slot_t slot_out
);

  slot_t             slot;
  slot_t             slot_next;
  wave_t             wave_next;
  logic              key_hit;
  logic              fire_now;
  logic [TIME_W-1:0] t_sub;
  logic [TIME_W:0]   t_sum;
  logic [TIME_W-1:0] t_new;

  assign slot_out = slot;
  assign hole_out = hole_in || !slot.used;
  assign key_hit  = slot.used && (slot.key == wave_in.key);

  always_comb begin
    fire_now = (slot.held == '0) || (slot.held >= cfg.hold_limit);
    if (slot.held == '0) begin
      t_sub = slot.held;
    end else if (slot.held >= cfg.hold_limit) begin
      t_sub = (slot.held > cfg.repeat_period) ? (slot.held - cfg.repeat_period) : '0;
    end else begin
      t_sub = slot.held;
    end
    t_sum = {1'b0, t_sub} + {1'b0, cfg.frame_step};
    t_new = (t_sum > {1'b0, cfg.hold_limit}) ? cfg.hold_limit : t_sum[TIME_W-1:0];
  end

  always_comb begin
    slot_next = slot;
    wave_next = wave_in;
    if (wave_in.valid) begin
      case (wave_in.op)
        OP_PRESS: begin
          if (wave_in.key != '0) begin
            if (key_hit && !wave_in.match) begin
              wave_next.match      = 1'b1;
              wave_next.match_time = slot.held;
              wave_next.match_fire = slot.fire;
            end else if (!slot.used && !wave_in.placed) begin
              slot_next.used   = 1'b1;
              slot_next.key    = wave_in.key;
              slot_next.held   = wave_in.match_time;
              slot_next.fire   = wave_in.match_fire;
              wave_next.placed = 1'b1;
            end
          end
        end
        OP_RELEASE: begin
          if (wave_in.key != '0 && key_hit) begin
            slot_next = '0;
          end
        end
        OP_TICK: begin
          if (slot.used) begin
            slot_next.held = t_new;
            slot_next.fire = fire_now;
          end
        end
        OP_POP: begin
          if (slot.used && slot.fire && !wave_in.found) begin
            wave_next.found     = 1'b1;
            wave_next.found_key = slot.key;
          end
        end
        default: ;
      endcase
    end else if (shift_en && hole_out) begin
      slot_next = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      wave_out <= '0;
    end else begin
      slot     <= slot_next;
      wave_out <= wave_next;
    end
  end

endmodule

### design/key_repeat_input_buffer_top.sv
// Top level of the key repeat input buffer: cell row, sequencer and result register.
// A command walks the row of BUFFER_SLOTS cells one cell per cycle, starting in the
// cycle it is accepted. Press, tick and pop register done once the command leaves the
// last cell; a release first compacts the row, shifting kept keys into emptied slots.
// A new transaction is taken in the cycle done is high; the receiver cannot stall.
// Synchronous reset empties every slot and loads the default timing registers.
module key_repeat_input_buffer_top
  import krib_pkg::*;
#(
  parameter int BUFFER_SLOTS = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [KEY_W-1:0]  key_code,
  output logic              done,
  output logic [KEY_W-1:0]  popped_key,
  output logic              key_found,
  output logic              buffer_empty,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  wave_t  wave_link [BUFFER_SLOTS+1];
  slot_t  slot_link [BUFFER_SLOTS+1];
  logic [BUFFER_SLOTS:0]   hole;
  logic [BUFFER_SLOTS-1:0] stray;
  logic   compact;
  logic   shift_en;
  logic   emit;
  wave_t  last_wave;

  krib_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    wave_link[0]       = '0;
    wave_link[0].valid = start && !busy;
    wave_link[0].op    = op_t'(operation);
    wave_link[0].key   = key_code;
  end

  assign hole[0]                 = 1'b0;
  assign slot_link[BUFFER_SLOTS] = '0;

  for (genvar i = 0; i < BUFFER_SLOTS; i++) begin : g_cell
    krib_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .wave_in   (wave_link[i]),
      .wave_out  (wave_link[i+1]),
      .shift_en  (shift_en),
      .hole_in   (hole[i]),
      .hole_out  (hole[i+1]),
      .next_slot (slot_link[i+1]),
      .slot_out  (slot_link[i])
    );
    assign stray[i] = hole[i] && slot_link[i].used;
  end

  assign compact   = ~|stray;
  assign last_wave = wave_link[BUFFER_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    shift_en   = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_WAVE;
        end
      end
      ST_WAVE: begin
        if (last_wave.valid) begin
          if (last_wave.op == OP_RELEASE) begin
            state_next = ST_COMPACT;
          end else begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_COMPACT: begin
        if (compact) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          shift_en = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      popped_key   <= last_wave.found ? last_wave.found_key : '0;
      key_found    <= last_wave.found;
      buffer_empty <= !slot_link[0].used;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

  a_idle_no_wave: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !last_wave.valid)
    else $error("command wave reached the end of the row while idle");

  a_idle_compact: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> compact)
    else $error("occupied slot behind an empty slot while idle");

endmodule
